@@ hdl/assert_macros.svh @@
// Assertion helpers included by equirect_viewport_remap.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EVR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define EVR_ASSERT(lbl, clk, rst_n, prop, msg)
`define EVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/evr_pkg.sv @@
package evr_pkg;

    // field widths
    localparam int VIEW_W   = 10;
    localparam int VEC_W    = 54;
    localparam int LANE_W   = 18;
    localparam int SCOL_W   = 12;
    localparam int SROW_W   = 11;
    localparam int IDX_W    = 23;
    localparam int CFG_IDX_W = 3;

    // internal widths
    localparam int RAY_W    = 29;        // |ray| < 2^28
    localparam int SQ_W     = 2 * RAY_W; // x*x + z*z
    localparam int ROOT_W   = RAY_W;
    localparam int CW       = 32;        // CORDIC x/y datapath
    localparam int ACC_W    = 34;        // angle accumulator
    localparam int WEFF_W   = 15;        // effective source width, up to 16384
    localparam int HEFF_W   = 14;        // effective source height, up to 8192

    // binary angle: pi = 2^31
    localparam logic signed [ACC_W-1:0] ANG_PI      = 34'sd2147483648;
    localparam logic signed [ACC_W-1:0] ANG_HALF_PI = 34'sd1073741824;

    localparam int ATAN_ENTRIES = 24;
    localparam logic [29:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CORNER     = 3'd0,
        CFG_COL_STEP   = 3'd1,
        CFG_ROW_STEP   = 3'd2,
        CFG_SRC_WIDTH  = 3'd3,
        CFG_SRC_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [RAY_W-1:0] x;
        logic signed [RAY_W-1:0] y;
        logic signed [RAY_W-1:0] z;
    } t_ray;

    // special-case flags that ride alongside the angle units
    typedef struct packed {
        logic r_zero;
        logic y_neg;
        logic x_zero;
    } t_flags;

    function automatic logic signed [LANE_W-1:0] lane(logic [VEC_W-1:0] v, int k);
        return $signed(v[LANE_W*k +: LANE_W]);
    endfunction

endpackage

@@ hdl/evr_in_if.sv @@
interface evr_in_if;
    logic                       valid;
    logic                       ready;
    logic [evr_pkg::VIEW_W-1:0] view_row;
    logic [evr_pkg::VIEW_W-1:0] view_column;

    modport source (output valid, output view_row, output view_column, input ready);
    modport sink   (input valid, input view_row, input view_column, output ready);
endinterface

@@ hdl/evr_out_if.sv @@
interface evr_out_if;
    logic                       valid;
    logic                       ready;
    logic [evr_pkg::SCOL_W-1:0] source_column;
    logic [evr_pkg::SROW_W-1:0] source_row;
    logic [evr_pkg::IDX_W-1:0]  pixel_index;

    modport source (output valid, output source_column, output source_row,
                    output pixel_index, input ready);
    modport sink   (input valid, input source_column, input source_row,
                    input pixel_index, output ready);
endinterface

@@ hdl/evr_isqrt.sv @@
// Pipelined floor square root, one result bit per stage; ray rides along.
module evr_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_v,
    input  logic [evr_pkg::SQ_W-1:0]     i_n,
    input  evr_pkg::t_ray                i_ray,
    output logic                         o_v,
    output logic [evr_pkg::ROOT_W-1:0]   o_root,
    output evr_pkg::t_ray                o_ray
);
    localparam int N_W   = evr_pkg::SQ_W;
    localparam int R_W   = evr_pkg::ROOT_W;
    localparam int REM_W = R_W + 2;

    logic [REM_W-1:0]   r_rem  [R_W];
    logic [R_W-1:0]     r_root [R_W];
    logic [N_W-1:0]     r_n    [R_W];
    evr_pkg::t_ray      r_ray  [R_W];
    logic               r_v    [R_W];

    genvar j;
    generate
        for (j = 0; j < R_W; j++) begin : g_stage
            logic [REM_W-1:0] p_rem;
            logic [R_W-1:0]   p_root;
            logic [N_W-1:0]   p_n;
            evr_pkg::t_ray    p_ray;
            logic             p_v;
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;
            logic             ge;
            logic [REM_W-1:0] n_rem;
            logic [R_W-1:0]   n_root;

            if (j == 0) begin : g_first
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_n    = i_n;
                assign p_ray  = i_ray;
                assign p_v    = i_v;
            end else begin : g_next
                assign p_rem  = r_rem[j-1];
                assign p_root = r_root[j-1];
                assign p_n    = r_n[j-1];
                assign p_ray  = r_ray[j-1];
                assign p_v    = r_v[j-1];
            end

            // bring down the next bit pair and try root*4+1
            always_comb begin
                rem_sh = {p_rem[REM_W-3:0], p_n[N_W-1 -: 2]};
                trial  = {p_root, 2'b01};
                ge     = (rem_sh >= trial);
                n_rem  = ge ? (rem_sh - trial) : rem_sh;
                n_root = {p_root[R_W-2:0], ge};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (i_en) begin
                    r_v[j] <= p_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j]  <= n_rem;
                    r_root[j] <= n_root;
                    r_n[j]    <= {p_n[N_W-3:0], 2'b00};
                    r_ray[j]  <= p_ray;
                end
            end
        end
    endgenerate

    assign o_v    = r_v[R_W-1];
    assign o_root = r_root[R_W-1];
    assign o_ray  = r_ray[R_W-1];
endmodule

@@ hdl/evr_cordic.sv @@
// Pipelined vectoring CORDIC: angle of point (b, a), one micro-rotation
// per stage after a quadrant pre-rotation stage.
module evr_cordic #(
    parameter int ITER = 16
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [evr_pkg::CW-1:0]      i_a,
    input  logic signed [evr_pkg::CW-1:0]      i_b,
    output logic signed [evr_pkg::ACC_W-1:0]   o_acc
);
    localparam int CW    = evr_pkg::CW;
    localparam int ACC_W = evr_pkg::ACC_W;

    logic signed [CW-1:0]    r_a   [ITER+1];
    logic signed [CW-1:0]    r_b   [ITER+1];
    logic signed [ACC_W-1:0] r_acc [ITER+1];

    logic signed [CW-1:0]    n_a0;
    logic signed [CW-1:0]    n_b0;
    logic signed [ACC_W-1:0] n_acc0;

    // fold the left half plane into the right one
    always_comb begin
        n_a0   = i_a;
        n_b0   = i_b;
        n_acc0 = '0;
        if (i_b < 0) begin
            if (i_a >= 0) begin
                n_a0   = -i_b;
                n_b0   = i_a;
                n_acc0 = evr_pkg::ANG_HALF_PI;
            end else begin
                n_a0   = i_b;
                n_b0   = -i_a;
                n_acc0 = -evr_pkg::ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0]   <= n_a0;
            r_b[0]   <= n_b0;
            r_acc[0] <= n_acc0;
        end
    end

    genvar j;
    generate
        for (j = 1; j <= ITER; j++) begin : g_iter
            logic signed [CW-1:0]    da;
            logic signed [CW-1:0]    db;
            logic signed [ACC_W-1:0] step;

            always_comb begin
                da   = r_a[j-1] >>> (j - 1);
                db   = r_b[j-1] >>> (j - 1);
                step = $signed({4'b0000, evr_pkg::ATAN_TABLE[j-1]});
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_a[j-1] >= 0) begin
                        r_b[j]   <= r_b[j-1] + da;
                        r_a[j]   <= r_a[j-1] - db;
                        r_acc[j] <= r_acc[j-1] + step;
                    end else begin
                        r_b[j]   <= r_b[j-1] - da;
                        r_a[j]   <= r_a[j-1] + db;
                        r_acc[j] <= r_acc[j-1] - step;
                    end
                end
            end
        end
    endgenerate

    assign o_acc = r_acc[ITER];
endmodule

@@ hdl/equirect_viewport_remap.sv @@
// Equirectangular viewport remap.
// Input channel i_in carries (view_row, view_column) of one viewport pixel;
// output channel o_out returns the matching source_column, source_row and
// pixel_index of the equirectangular image. One result per transfer, in order.
// The user must write the ray vectors and source size on the i_cfg_* port
// only while idle; the block itself does not enforce this.
// Register stages from input transfer to o_out.valid: 4 ray/square stages,
// 29 square-root stages (one root bit each), ANGLE_ITERATIONS + 1 CORDIC
// stages, 5 scaling and index stages and the output register.
// Throughput: one pixel per clock until a receiver stall fills the skid register.
// Receiver stall: the pipeline keeps moving until a one-entry skid register
// behind the output register fills; only then does i_in.ready drop, and it
// rises again the cycle after the waiting result is taken.
// Reset: synchronous, active low; clears all valid bits, vectors to zero,
// source size to 4096 x 2048. No clearing pass is needed.
`include "assert_macros.svh"

module equirect_viewport_remap #(
    parameter int VIEW_MAX_WIDTH    = 1024,
    parameter int VIEW_MAX_HEIGHT   = 1024,
    parameter int SOURCE_MAX_WIDTH  = 4096,
    parameter int SOURCE_MAX_HEIGHT = 2048,
    parameter int ANGLE_ITERATIONS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    evr_in_if.sink                            i_in,
    evr_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [evr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [evr_pkg::VEC_W-1:0]         i_cfg_data
);
    localparam int RAY_W  = evr_pkg::RAY_W;
    localparam int SQ_W   = evr_pkg::SQ_W;
    localparam int CW     = evr_pkg::CW;
    localparam int ACC_W  = evr_pkg::ACC_W;
    localparam int WEFF_W = evr_pkg::WEFF_W;
    localparam int HEFF_W = evr_pkg::HEFF_W;
    localparam int CD     = ANGLE_ITERATIONS + 1;

    // ------------------------------------------------------------ config
    logic [evr_pkg::VEC_W-1:0] r_corner;
    logic [evr_pkg::VEC_W-1:0] r_col_step;
    logic [evr_pkg::VEC_W-1:0] r_row_step;
    logic [12:0]               r_src_w;
    logic [11:0]               r_src_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner   <= '0;
            r_col_step <= '0;
            r_row_step <= '0;
            r_src_w    <= 13'd4096;
            r_src_h    <= 12'd2048;
        end else if (i_cfg_we) begin
            case (evr_pkg::t_cfg_idx'(i_cfg_idx))
                evr_pkg::CFG_CORNER:     r_corner   <= i_cfg_data;
                evr_pkg::CFG_COL_STEP:   r_col_step <= i_cfg_data;
                evr_pkg::CFG_ROW_STEP:   r_row_step <= i_cfg_data;
                evr_pkg::CFG_SRC_WIDTH:  r_src_w    <= i_cfg_data[12:0];
                evr_pkg::CFG_SRC_HEIGHT: r_src_h    <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // effective source size, clamped to [2, max]
    logic [WEFF_W-1:0] w_eff;
    logic [HEFF_W-1:0] h_eff;
    logic [WEFF_W-1:0] w_m1;
    logic [HEFF_W-1:0] h_m1;

    always_comb begin
        w_eff = {2'b00, r_src_w};
        if (w_eff < WEFF_W'(2))
            w_eff = WEFF_W'(2);
        if (w_eff > WEFF_W'(SOURCE_MAX_WIDTH))
            w_eff = WEFF_W'(SOURCE_MAX_WIDTH);
        h_eff = {2'b00, r_src_h};
        if (h_eff < HEFF_W'(2))
            h_eff = HEFF_W'(2);
        if (h_eff > HEFF_W'(SOURCE_MAX_HEIGHT))
            h_eff = HEFF_W'(SOURCE_MAX_HEIGHT);
        w_m1 = w_eff - WEFF_W'(1);
        h_m1 = h_eff - HEFF_W'(1);
    end

    // ---------------------------------------------------- flow control
    logic r_skid_v;
    logic en;
    assign en          = !r_skid_v;
    assign i_in.ready  = en;

    logic in_fire;
    assign in_fire = i_in.valid && i_in.ready;

    // ------------------------------------------ S1: step products
    logic [evr_pkg::VIEW_W-1:0] row_sat;
    logic [evr_pkg::VIEW_W-1:0] col_sat;
    logic signed [RAY_W-1:0]    n_pc [3];
    logic signed [RAY_W-1:0]    n_pr [3];
    logic signed [RAY_W-1:0]    r_pc [3];
    logic signed [RAY_W-1:0]    r_pr [3];
    logic                       r_s1_v;

    always_comb begin
        row_sat = i_in.view_row;
        col_sat = i_in.view_column;
        if ({3'b000, i_in.view_row} > 13'(VIEW_MAX_HEIGHT - 1))
            row_sat = evr_pkg::VIEW_W'(VIEW_MAX_HEIGHT - 1);
        if ({3'b000, i_in.view_column} > 13'(VIEW_MAX_WIDTH - 1))
            col_sat = evr_pkg::VIEW_W'(VIEW_MAX_WIDTH - 1);
        for (int k = 0; k < 3; k++) begin
            n_pc[k] = $signed({1'b0, col_sat}) * evr_pkg::lane(r_col_step, k);
            n_pr[k] = $signed({1'b0, row_sat}) * evr_pkg::lane(r_row_step, k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_pc[k] <= n_pc[k];
                r_pr[k] <= n_pr[k];
            end
        end
    end

    // ------------------------------------------------ S2: ray sum
    evr_pkg::t_ray r_s2_ray;
    logic          r_s2_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_ray.x <= evr_pkg::lane(r_corner, 0) + r_pc[0] + r_pr[0];
            r_s2_ray.y <= evr_pkg::lane(r_corner, 1) + r_pc[1] + r_pr[1];
            r_s2_ray.z <= evr_pkg::lane(r_corner, 2) + r_pc[2] + r_pr[2];
        end
    end

    // --------------------------------------------- S3: squares
    logic signed [SQ_W-1:0] n_sqx;
    logic signed [SQ_W-1:0] n_sqz;
    logic [SQ_W-1:0]        r_sqx;
    logic [SQ_W-1:0]        r_sqz;
    evr_pkg::t_ray          r_s3_ray;
    logic                   r_s3_v;

    always_comb begin
        n_sqx = r_s2_ray.x * r_s2_ray.x;
        n_sqz = r_s2_ray.z * r_s2_ray.z;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx    <= n_sqx;
            r_sqz    <= n_sqz;
            r_s3_ray <= r_s2_ray;
        end
    end

    // ------------------------------------- S4: horizontal radius^2
    logic [SQ_W-1:0] r_s4_n;
    evr_pkg::t_ray   r_s4_ray;
    logic            r_s4_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_n   <= r_sqx + r_sqz;
            r_s4_ray <= r_s3_ray;
        end
    end

    // front-end valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= in_fire;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    // ----------------------------------------------- square root
    logic                         sq_v;
    logic [evr_pkg::ROOT_W-1:0]   sq_root;
    evr_pkg::t_ray                sq_ray;

    evr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (r_s4_v),
        .i_n     (r_s4_n),
        .i_ray   (r_s4_ray),
        .o_v     (sq_v),
        .o_root  (sq_root),
        .o_ray   (sq_ray)
    );

    // ------------------------------------------------- angle units
    logic signed [CW-1:0]    th_a;
    logic signed [CW-1:0]    th_b;
    logic signed [CW-1:0]    ph_a;
    logic signed [CW-1:0]    ph_b;
    logic signed [ACC_W-1:0] th_acc;
    logic signed [ACC_W-1:0] ph_acc;
    evr_pkg::t_flags         n_flags;

    always_comb begin
        th_a = $signed({3'b000, sq_root});
        th_b = $signed({{(CW-RAY_W){sq_ray.y[RAY_W-1]}}, sq_ray.y});
        ph_a = $signed({{(CW-RAY_W){sq_ray.x[RAY_W-1]}}, sq_ray.x});
        ph_b = $signed({{(CW-RAY_W){sq_ray.z[RAY_W-1]}}, sq_ray.z});
        n_flags.r_zero = (sq_root == '0);
        n_flags.y_neg  = sq_ray.y[RAY_W-1];
        n_flags.x_zero = (sq_ray.x == '0);
    end

    evr_cordic #(.ITER(ANGLE_ITERATIONS)) u_cordic_theta (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (th_a),
        .i_b   (th_b),
        .o_acc (th_acc)
    );

    evr_cordic #(.ITER(ANGLE_ITERATIONS)) u_cordic_phi (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (ph_a),
        .i_b   (ph_b),
        .o_acc (ph_acc)
    );

    // valid and special-case flags aligned with the CORDIC stages
    logic            r_cv [CD];
    evr_pkg::t_flags r_cf [CD];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CD; k++)
                r_cv[k] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= sq_v;
            for (int k = 1; k < CD; k++)
                r_cv[k] <= r_cv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cf[0] <= n_flags;
            for (int k = 1; k < CD; k++)
                r_cf[k] <= r_cf[k-1];
        end
    end

    // ------------------------------- P1: special cases and clamps
    logic [31:0]             n_theta;
    logic signed [ACC_W-1:0] phi_c;
    logic signed [ACC_W-1:0] phi_sum;
    logic [32:0]             n_phipi;
    logic [31:0]             r_theta;
    logic [32:0]             r_phipi;
    logic                    r_p1_v;

    always_comb begin
        if (r_cf[CD-1].r_zero)
            n_theta = r_cf[CD-1].y_neg ? evr_pkg::ANG_PI[31:0] : 32'd0;
        else if (th_acc < 0)
            n_theta = 32'd0;
        else if (th_acc > evr_pkg::ANG_PI)
            n_theta = evr_pkg::ANG_PI[31:0];
        else
            n_theta = th_acc[31:0];

        if (r_cf[CD-1].x_zero)
            phi_c = '0;
        else if (ph_acc < -evr_pkg::ANG_PI)
            phi_c = -evr_pkg::ANG_PI;
        else if (ph_acc > evr_pkg::ANG_PI)
            phi_c = evr_pkg::ANG_PI;
        else
            phi_c = ph_acc;
        phi_sum = phi_c + evr_pkg::ANG_PI;
        n_phipi = phi_sum[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_theta <= n_theta;
            r_phipi <= n_phipi;
        end
    end

    // ------------------------------------------ P2: scale products
    logic [32+WEFF_W:0]  r_prod_c;
    logic [31+HEFF_W:0]  r_prod_r;
    logic                r_p2_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod_c <= r_phipi * w_m1;
            r_prod_r <= r_theta * h_m1;
        end
    end

    // --------------------------------- P3: truncate and clamp
    logic [WEFF_W:0]   scol_full;
    logic [HEFF_W:0]   srow_full;
    logic [WEFF_W-1:0] r_scol;
    logic [HEFF_W-1:0] r_srow;
    logic              r_p3_v;

    always_comb begin
        scol_full = r_prod_c[32+WEFF_W:32];
        srow_full = r_prod_r[31+HEFF_W:31];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_scol <= (scol_full > {1'b0, w_m1}) ? w_m1 : scol_full[WEFF_W-1:0];
            r_srow <= (srow_full > {1'b0, h_m1}) ? h_m1 : srow_full[HEFF_W-1:0];
        end
    end

    // ------------------------------------------- P4: row * width
    logic [WEFF_W+HEFF_W-1:0] r_idx_prod;
    logic [WEFF_W-1:0]        r_p4_scol;
    logic [HEFF_W-1:0]        r_p4_srow;
    logic                     r_p4_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idx_prod <= r_srow * w_eff;
            r_p4_scol  <= r_scol;
            r_p4_srow  <= r_srow;
        end
    end

    // ------------------------------------------- P5: pixel index
    logic [WEFF_W+HEFF_W-1:0] idx_sum;
    logic [evr_pkg::SCOL_W-1:0] r_p5_scol;
    logic [evr_pkg::SROW_W-1:0] r_p5_srow;
    logic [evr_pkg::IDX_W-1:0]  r_p5_idx;
    logic                       r_p5_v;

    assign idx_sum = r_idx_prod + {{HEFF_W{1'b0}}, r_p4_scol};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p5_scol <= r_p4_scol[evr_pkg::SCOL_W-1:0];
            r_p5_srow <= r_p4_srow[evr_pkg::SROW_W-1:0];
            r_p5_idx  <= idx_sum[evr_pkg::IDX_W-1:0];
        end
    end

    // back-end valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_p5_v <= 1'b0;
        end else if (en) begin
            r_p1_v <= r_cv[CD-1];
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
            r_p5_v <= r_p4_v;
        end
    end

    // ------------------------------------- output register and skid
    logic                       r_out_v;
    logic [evr_pkg::SCOL_W-1:0] r_out_scol;
    logic [evr_pkg::SROW_W-1:0] r_out_srow;
    logic [evr_pkg::IDX_W-1:0]  r_out_idx;
    logic [evr_pkg::SCOL_W-1:0] r_skid_scol;
    logic [evr_pkg::SROW_W-1:0] r_skid_srow;
    logic [evr_pkg::IDX_W-1:0]  r_skid_idx;
    logic                       out_fire;

    assign out_fire = r_out_v && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_fire) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || out_fire) begin
            r_out_v <= r_p5_v;
        end else if (r_p5_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_fire) begin
                r_out_scol <= r_skid_scol;
                r_out_srow <= r_skid_srow;
                r_out_idx  <= r_skid_idx;
            end
        end else if (!r_out_v || out_fire) begin
            r_out_scol <= r_p5_scol;
            r_out_srow <= r_p5_srow;
            r_out_idx  <= r_p5_idx;
        end else begin
            r_skid_scol <= r_p5_scol;
            r_skid_srow <= r_p5_srow;
            r_skid_idx  <= r_p5_idx;
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.source_column = r_out_scol;
    assign o_out.source_row    = r_out_srow;
    assign o_out.pixel_index   = r_out_idx;

    // ------------------------------------------------- assertions
    `EVR_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_v |-> r_out_v, "skid full with empty output")
    `EVR_ASSERT_NEXT(a_skid_hold, i_clk, i_rst_n, r_skid_v && !out_fire, r_skid_v, "skid entry lost")
    `EVR_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, r_out_v && !o_out.ready && !r_skid_v && r_p5_v, r_skid_v && r_out_v, "stalled result dropped")
endmodule
